@@ design/round_robin_time_slice_scheduler_assert.svh @@
// Assertion macros for the round-robin scheduler checker.
// Clock clk_i and active-low reset rst_ni are taken from the including scope.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define RRTS_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRTS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rrts_pkg.sv @@
// Shared types and constants for the round-robin time-slice scheduler.
// No dependencies.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int ID_W       = 4;
  localparam int RT_W       = 16;
  localparam int SLICE_W    = 8;
  localparam int QCNT_W     = 5;
  localparam int TIME_W     = 16;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_ARRIVE = 1'b1
  } op_e;

  // Input word, lowest field in the lowest bits.
  typedef struct packed {
    logic [3:0]      pad;
    logic [RT_W-1:0] job_len;
    logic [ID_W-1:0] task_id;
  } in_word_t;

  // Result word, lowest field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic [TIME_W-1:0] current_time;
    logic [QCNT_W-1:0] queue_count;
    logic              rejected;
    logic              first_dispatch;
    logic              context_switch;
    logic              task_done;
    logic              cpu_busy;
    logic [ID_W-1:0]   running_task;
  } res_word_t;

endpackage

@@ design/round_robin_time_slice_scheduler.sv @@
// Round-robin time-slice scheduler, one word per cycle in and out unless the result stream stalls.
// The result register makes the result valid in the cycle after the input is accepted.
// All tick/arrival work is one combinational pass
// over the queue pointers, the remaining-time store and the task flags.
// Reset (rst_ni low, async): queue empty, no task active, CPU idle, time 0,
// slice length 4. Queue and remaining-time entries are not cleared.
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: slice length in ticks
  input  logic                                cfg_we_i,
  input  logic [rrts_pkg::SLICE_W-1:0]        cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: task_id[3:0], job_len[19:4], zero pad[23:20]
  input  logic [rrts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: op[0] (0 = tick, 1 = arrival)
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: running_task[3:0], cpu_busy[4], task_done[5], context_switch[6],
  //        first_dispatch[7], rejected[8], queue_count[13:9],
  //        current_time[29:14], zero pad[31:30]
  output logic [rrts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rrts_pkg::*;

  // Only ids below both MAX_TASKS and the 4-bit id range can ever be stored,
  // so the queue and per-task stores are sized to that.
  localparam int NID   = (MAX_TASKS < (1 << ID_W)) ? MAX_TASKS : (1 << ID_W);
  localparam int IDX_W = $clog2(NID);
  localparam int CNT_W = $clog2(NID + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NID - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NID);
  localparam logic [8:0]       ID_LIMIT = 9'(MAX_TASKS);

  // Storage without reset: entries are read only after being written.
  logic [ID_W-1:0] fifo_q [NID];
  logic [RT_W-1:0] rem_q  [NID];

  // Control state
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [NID-1:0]     active_q, active_d, started_q, started_d;
  logic [ID_W-1:0]    cur_q, cur_d;
  logic               hold_q, hold_d;
  logic [SLICE_W-1:0] slice_q, slice_d;
  logic               rq_q, rq_d;
  logic [ID_W-1:0]    last_q, last_d;
  logic               last_vld_q, last_vld_d;
  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [SLICE_W-1:0] tslice_q;

  // Result register
  logic               m_vld_q, m_vld_d;
  res_word_t          m_data_q, m_data_d;

  // Write ports
  logic               fifo_we, rem_we;
  logic [ID_W-1:0]    fifo_wdata;
  logic [IDX_W-1:0]   rem_widx;
  logic [RT_W-1:0]    rem_wdata;

  logic               accept;
  in_word_t           in_w;

  assign in_w          = in_word_t'(s_axis_tdata);
  // Output register frees up in the same cycle it is drained.
  assign s_axis_tready = !m_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    logic [IDX_W-1:0]   arr_idx;
    logic               reject;
    logic [SLICE_W-1:0] limit;
    logic               push;
    logic [CNT_W-1:0]   cnt1;
    logic               dispatch;
    logic [ID_W-1:0]    pop_id;
    logic [ID_W-1:0]    run_id;
    logic [IDX_W-1:0]   ridx;
    logic               busy;
    logic [RT_W-1:0]    rem_cur, rem_nxt;
    logic [SLICE_W-1:0] slice_base, slice_nxt;
    res_word_t          res;

    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    active_d   = active_q;
    started_d  = started_q;
    cur_d      = cur_q;
    hold_d     = hold_q;
    slice_d    = slice_q;
    rq_d       = rq_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    tick_d     = tick_q;
    fifo_we    = 1'b0;
    fifo_wdata = cur_q;
    rem_we     = 1'b0;
    rem_widx   = '0;
    rem_wdata  = in_w.job_len;
    res        = '0;

    arr_idx    = in_w.task_id[IDX_W-1:0];
    reject     = ({5'b0, in_w.task_id} >= ID_LIMIT) || (in_w.job_len == '0) ||
                 active_q[arr_idx] || (count_q >= FULL_CNT);

    // A zero slice behaves as one tick.
    limit      = (tslice_q == '0) ? SLICE_W'(1) : tslice_q;
    push       = rq_q && (count_q < FULL_CNT);
    cnt1       = count_q + CNT_W'(push);
    dispatch   = !hold_q && (cnt1 != '0);
    // Requeue into an empty queue: the head is the task just pushed.
    pop_id     = (count_q == '0) ? cur_q : fifo_q[head_q];
    run_id     = dispatch ? pop_id : cur_q;
    ridx       = run_id[IDX_W-1:0];
    busy       = dispatch || hold_q;
    rem_cur    = rem_q[ridx];
    rem_nxt    = (rem_cur != '0) ? rem_cur - RT_W'(1) : rem_cur;
    slice_base = dispatch ? '0 : slice_q;
    slice_nxt  = (slice_base != SLICE_MAX) ? slice_base + SLICE_W'(1) : slice_base;

    if (accept) begin
      if (s_axis_tuser == OP_ARRIVE) begin
        if (!reject) begin
          rem_we             = 1'b1;
          rem_widx           = arr_idx;
          rem_wdata          = in_w.job_len;
          active_d[arr_idx]  = 1'b1;
          started_d[arr_idx] = 1'b0;
          fifo_we            = 1'b1;
          fifo_wdata         = in_w.task_id;
          tail_d             = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
          count_d            = count_q + CNT_W'(1);
        end
        res.rejected = reject;
      end else begin
        rq_d = 1'b0;
        // Put back the task preempted on the previous tick.
        if (push) begin
          fifo_we    = 1'b1;
          fifo_wdata = cur_q;
          tail_d     = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
        end
        if (dispatch) begin
          head_d     = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
          last_d     = pop_id;
          last_vld_d = 1'b1;
          started_d[ridx]      = 1'b1;
          res.first_dispatch   = !started_q[ridx];
          res.context_switch   = last_vld_q && (last_q != pop_id);
        end
        count_d = cnt1 - CNT_W'(dispatch);
        if (busy) begin
          rem_we    = 1'b1;
          rem_widx  = ridx;
          rem_wdata = rem_nxt;
          cur_d     = run_id;
          slice_d   = slice_nxt;
          hold_d    = 1'b1;
          if (rem_nxt == '0) begin
            res.task_done  = 1'b1;
            active_d[ridx] = 1'b0;
            hold_d         = 1'b0;
          end else if (slice_nxt >= limit) begin
            hold_d = 1'b0;
            rq_d   = 1'b1;
          end
          res.cpu_busy     = 1'b1;
          res.running_task = run_id;
        end
        tick_d = tick_q + TIME_W'(1);
      end
      res.queue_count  = QCNT_W'(count_d);
      res.current_time = tick_d;
    end

    m_data_d = accept ? res : m_data_q;
    if (accept) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end else begin
      m_vld_d = m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[tail_q] <= fifo_wdata;
    end
    if (rem_we) begin
      rem_q[rem_widx] <= rem_wdata;
    end
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      active_q   <= '0;
      started_q  <= '0;
      cur_q      <= '0;
      hold_q     <= 1'b0;
      slice_q    <= '0;
      rq_q       <= 1'b0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      tick_q     <= '0;
      tslice_q   <= SLICE_RESET;
      m_vld_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      active_q   <= active_d;
      started_q  <= started_d;
      cur_q      <= cur_d;
      hold_q     <= hold_d;
      slice_q    <= slice_d;
      rq_q       <= rq_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
      tick_q     <= tick_d;
      m_vld_q    <= m_vld_d;
      if (cfg_we_i) begin
        tslice_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ design/rrts_checker.sv @@
// Port-level checks for the round-robin scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_time_slice_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "round_robin_time_slice_scheduler_assert.svh"

module rrts_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rrts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rrts_pkg::*;

  res_word_t r;
  logic      in_acc;
  logic      out_stall;
  logic      tick_flag;

  assign r         = res_word_t'(m_axis_tdata);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign tick_flag = r.task_done || r.context_switch || r.first_dispatch;

  // held result word stays put
  `RRTS_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "word changed while stalled")
  // every accepted word produces a result next cycle
  `RRTS_ASSERT_NEXT(a_one_result, in_acc, m_axis_tvalid, "accepted word gave no result")
  // rejected arrival results never show a running or finished task
  `RRTS_ASSERT_NOW(a_rej_idle, m_axis_tvalid && r.rejected, !r.cpu_busy && !r.task_done, "rejected busy")
  // done, switch and first dispatch only on a busy tick
  `RRTS_ASSERT_NOW(a_flags_busy, m_axis_tvalid && tick_flag, r.cpu_busy, "tick flag while idle")

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);
